[rtl/svpd_pkg.sv]
package svpd_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_W     = 1;
  localparam int TIME_W   = 32;
  localparam int US_W     = 16;
  localparam int DZ_W     = 8;
  localparam int PCT_W    = 8;
  localparam int CFG_IDX_W = 2;

  // magnitude of a span difference times the scale factor
  localparam int SCALE     = 120;
  localparam int PCT_MAX   = 120;
  localparam int ZERO_SPAN = 240;
  localparam int NUM_W     = 23;
  localparam int DEN_W     = US_W;
  localparam int ACC_W     = NUM_W + 2;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 2'd0,
    REG_MIN    = 2'd1,
    REG_MAX    = 2'd2,
    REG_DEAD   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] rise_time;
    logic              held;
    logic              new_pos;
  } entry_t;

endpackage

[rtl/servo_pulse_decoder_top.sv]
// servo pulse decoder
// input channel (in_valid/in_ready) takes one event item per handshake: a pin
// edge (action 0, level gives the edge direction) or an acknowledge (action 1)
// that clears the channel's new-position flag. a falling edge that follows a
// held rising edge, while no position is pending, yields one result item on
// the output channel (out_valid/out_ready): pulse width, percent position and
// the event's millisecond time. other events yield no item.
// per-channel state lives in a small synchronous memory, read in the cycle
// after the item is taken, then modified and written back before the next
// item. an event without a result ends after the read and update steps; a
// decoded falling edge goes on through setup, the 23-step restoring divider
// that scales the pulse to percent, and done; the divide is skipped for a
// pulse inside the dead zone or a zero span. one item is in work at a time.
// the output register holds a finished item while the next event is taken;
// if out_ready stays low, the next decode waits in its last step until the
// register frees up.
// configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken outside reset and must only be issued while the block is idle.
// reset (synchronous, active high) loads the default limits, clears all
// channel entries through their valid bits and empties the output register.
module servo_pulse_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [svpd_pkg::CH_W-1:0]      channel,
  input  logic                           level,
  input  logic [svpd_pkg::TIME_W-1:0]    time_us,
  input  logic [svpd_pkg::TIME_W-1:0]    time_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [svpd_pkg::CH_W-1:0]      out_channel,
  output logic [svpd_pkg::US_W-1:0]      pulse_us,
  output logic signed [svpd_pkg::PCT_W-1:0] percent,
  output logic [svpd_pkg::TIME_W-1:0]    update_ms,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [svpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svpd_pkg::US_W-1:0]      cfg_data
);
  import svpd_pkg::*;

  state_t state, state_next;

  logic [US_W-1:0] center_us, min_us, max_us;
  logic [DZ_W-1:0] dead_zone;

  // latched item
  logic              it_action;
  logic [CH_W-1:0]   it_channel;
  logic              it_level;
  logic [TIME_W-1:0] it_time_us;
  logic [TIME_W-1:0] it_time_ms;

  // channel state memory
  entry_t          mem [CHANNELS];
  logic [CHANNELS-1:0] mem_vld;
  entry_t          rd_entry;
  logic            rd_hit;
  entry_t          entry;
  entry_t          wr_entry;
  logic            mem_we;
  logic            mem_rd;

  logic            ch_ok;
  logic            fall_ok;
  logic            in_take;
  logic            out_load;

  // percent datapath
  logic [US_W-1:0]  pulse;
  logic [US_W:0]    hi_thr;
  logic signed [US_W+1:0] lo_thr;
  logic             case_hi, case_lo;
  logic [US_W-1:0]  diff_hi;
  logic signed [US_W:0] diff_lo;
  logic [US_W-1:0]  mag_lo;
  logic [US_W-1:0]  num_base;
  logic             num_neg;
  logic [NUM_W-1:0] num_mag;
  logic signed [US_W:0] den_s;
  logic [DEN_W-1:0] den_mag;

  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;
  logic [DEN_W-1:0] div_den;
  logic [CNT_W-1:0] div_cnt;
  logic [DEN_W:0]   rem_sh;
  logic             rem_ge;
  logic             q_neg, q_num_neg, q_num_zero, q_den_zero, q_bias, q_zero;

  logic signed [ACC_W-1:0] q_s;
  logic signed [ACC_W-1:0] r_s;
  logic signed [PCT_W-1:0] pct_val;

  function automatic logic q_zero_next();
    q_zero_next = !case_hi && !case_lo;
  endfunction

  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_us <= US_W'(1500);
      min_us    <= US_W'(1000);
      max_us    <= US_W'(2000);
      dead_zone <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER: center_us <= cfg_data;
        REG_MIN:    min_us    <= cfg_data;
        REG_MAX:    max_us    <= cfg_data;
        REG_DEAD:   dead_zone <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = fall_ok ? ST_SETUP : ST_IDLE;
      ST_SETUP:  state_next = (q_zero_next() || den_mag == '0) ? ST_DONE : ST_DIV;
      ST_DIV:    if (div_cnt == CNT_W'(1)) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    mem_rd   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:   in_ready = !rst;
      ST_READ:   mem_rd   = 1'b1;
      ST_UPDATE: mem_we   = ch_ok && (it_action || it_level || fall_ok);
      ST_DONE:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      it_action  <= action;
      it_channel <= channel;
      it_level   <= level;
      it_time_us <= time_us;
      it_time_ms <= time_ms;
    end
  end

  // memory: registered read, write back in the update step
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_entry <= mem[it_channel];
    end
    if (mem_we) begin
      mem[it_channel] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (mem_rd) begin
        rd_hit <= mem_vld[it_channel];
      end
      if (mem_we) begin
        mem_vld[it_channel] <= 1'b1;
      end
    end
  end

  // entry never written reads as the reset value
  assign entry = rd_hit ? rd_entry : '0;
  assign ch_ok = (32'(it_channel) < CHANNELS);
  assign fall_ok = ch_ok && !it_action && !it_level && entry.held && !entry.new_pos;

  always_comb begin
    wr_entry = entry;
    if (it_action) begin
      wr_entry.new_pos = 1'b0;
    end else if (it_level) begin
      wr_entry.rise_time = it_time_us;
      wr_entry.held      = 1'b1;
    end else begin
      wr_entry.held    = 1'b0;
      wr_entry.new_pos = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      pulse <= it_time_us[US_W-1:0] - entry.rise_time[US_W-1:0];
    end
  end

  // region select and span setup
  always_comb begin
    hi_thr  = {1'b0, center_us} + (US_W+1)'(dead_zone);
    lo_thr  = $signed({2'b00, center_us}) - $signed((US_W+2)'(dead_zone));
    case_hi = ({1'b0, pulse} >= hi_thr);
    case_lo = !case_hi && ($signed({2'b00, pulse}) <= lo_thr);
    diff_hi = pulse - center_us;
    diff_lo = $signed({1'b0, pulse}) - $signed({1'b0, min_us});
    mag_lo  = diff_lo[US_W] ? US_W'(-diff_lo) : diff_lo[US_W-1:0];
    num_base = case_hi ? diff_hi : mag_lo;
    num_neg  = case_lo && diff_lo[US_W];
    num_mag  = NUM_W'(num_base) * NUM_W'(SCALE);
    den_s    = case_hi ? ($signed({1'b0, max_us}) - $signed({1'b0, center_us}))
                       : ($signed({1'b0, center_us}) - $signed({1'b0, min_us}));
    den_mag  = den_s[US_W] ? DEN_W'(-den_s) : den_s[DEN_W-1:0];
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {div_rem, div_quo[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      div_quo    <= num_mag;
      div_rem    <= '0;
      div_den    <= den_mag;
      div_cnt    <= CNT_W'(NUM_W);
      q_neg      <= num_neg ^ den_s[US_W];
      q_num_neg  <= num_neg;
      q_num_zero <= (num_base == '0);
      q_den_zero <= (den_mag == '0);
      q_bias     <= case_lo;
      q_zero     <= q_zero_next();
    end else if (state == ST_DIV) begin
      div_rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, div_den}) : rem_sh[DEN_W-1:0];
      div_quo <= {div_quo[NUM_W-2:0], rem_ge};
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // sign, offset and clamp
  always_comb begin
    if (q_den_zero) begin
      if (q_num_zero) begin
        q_s = '0;
      end else begin
        q_s = q_num_neg ? -ACC_W'(ZERO_SPAN) : ACC_W'(ZERO_SPAN);
      end
    end else begin
      q_s = q_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    end
    r_s = q_s - (q_bias ? ACC_W'(SCALE) : ACC_W'(0));
    if (q_zero) begin
      pct_val = '0;
    end else if (r_s > $signed(ACC_W'(PCT_MAX))) begin
      pct_val = PCT_W'(PCT_MAX);
    end else if (r_s < -$signed(ACC_W'(PCT_MAX))) begin
      pct_val = -PCT_W'(PCT_MAX);
    end else begin
      pct_val = r_s[PCT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= it_channel;
      pulse_us    <= pulse;
      percent     <= pct_val;
      update_ms   <= it_time_ms;
    end
  end

endmodule
